FILE: rtl/gbe_pkg.sv
`timescale 1ns / 1ps

package gbe_pkg;

   localparam int CAPACITY_DEF = 1024;

   localparam int OP_W    = 2;
   localparam int POS_W   = 10;
   localparam int CHAR_W  = 8;
   localparam int STAT_W  = 2;
   localparam int START_W = 11;
   localparam int END_W   = 10;

   localparam logic [CHAR_W-1:0] RESET_FILL = 8'h5F;

   localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
   localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
   localparam logic [OP_W-1:0] OP_READ   = 2'd2;

   localparam logic [STAT_W-1:0] STAT_DONE  = 2'd0;
   localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
   localparam logic [STAT_W-1:0] STAT_RANGE = 2'd2;

   typedef struct packed {
      logic [STAT_W-1:0]  status;
      logic [CHAR_W-1:0]  read_char;
      logic [START_W-1:0] gap_start;
      logic [END_W-1:0]   gap_end;
   } rsp_type;

endpackage

FILE: rtl/gap_buffer_editor.sv
`timescale 1ns / 1ps

// channel  | ports                                       | dir | word
// ---------+---------------------------------------------+-----+---------------------------
// req      | req_valid req_ready req_op/position/char_in | in  | one insert, delete or read
// rsp      | rsp_valid rsp_ready rsp_status/read_char/   | out | status, slot data and the
//          |   gap_start/gap_end                         |     |   gap bounds after the item
// csr      | csr_valid csr_ready csr_fill_char           | in  | new fill character
//
// One item at a time. A read, a rejected edit or an edit right at the gap is answered from
// the check state. An edit d characters away from the gap first moves each character with
// a store read and its write-back on the single write port, plus one fill write and the edit.
// After reset a clearing pass writes the reset fill character into all CAPACITY slots,
// one slot a cycle; req_ready stays low during that pass. csr words are taken at any time.
// A result waiting in the rsp register does not block the next request; the core stalls
// only when it has a new result and the register is still full.

module gap_buffer_editor #(
   parameter int CAPACITY = gbe_pkg::CAPACITY_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [gbe_pkg::OP_W-1:0]     req_op,
   input  logic [gbe_pkg::POS_W-1:0]    req_position,
   input  logic [gbe_pkg::CHAR_W-1:0]   req_char_in,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [gbe_pkg::STAT_W-1:0]   rsp_status,
   output logic [gbe_pkg::CHAR_W-1:0]   rsp_read_char,
   output logic [gbe_pkg::START_W-1:0]  rsp_gap_start,
   output logic [gbe_pkg::END_W-1:0]    rsp_gap_end,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [gbe_pkg::CHAR_W-1:0]   csr_fill_char
);
   import gbe_pkg::*;

   logic [CHAR_W-1:0] fill_ff, fill_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;
   rsp_type           core_rsp;
   logic              core_done;
   logic              rsp_free;

   // output register is free when empty or draining this cycle
   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign csr_ready = 1'b1;

   gbe_core #(
      .CAPACITY (CAPACITY)
   ) u_core (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_op       (req_op),
      .req_position (req_position),
      .req_char_in  (req_char_in),
      .fill_char    (fill_ff),
      .rsp_free     (rsp_free),
      .done         (core_done),
      .rsp          (core_rsp)
   );

   always_comb begin
      fill_in      = csr_valid ? csr_fill_char : fill_ff;
      rsp_in       = core_done ? core_rsp : rsp_ff;
      rsp_valid_in = core_done ? 1'b1 : (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= RESET_FILL;
         rsp_valid_ff <= 1'b0;
      end else begin
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_ff.status;
   assign rsp_read_char = rsp_ff.read_char;
   assign rsp_gap_start = rsp_ff.gap_start;
   assign rsp_gap_end   = rsp_ff.gap_end;

endmodule

FILE: rtl/gbe_core.sv
`timescale 1ns / 1ps

module gbe_core #(
   parameter int CAPACITY = gbe_pkg::CAPACITY_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [gbe_pkg::OP_W-1:0]    req_op,
   input  logic [gbe_pkg::POS_W-1:0]   req_position,
   input  logic [gbe_pkg::CHAR_W-1:0]  req_char_in,
   input  logic [gbe_pkg::CHAR_W-1:0]  fill_char,
   input  logic                        rsp_free,
   output logic                        done,
   output gbe_pkg::rsp_type            rsp
);
   import gbe_pkg::*;

   localparam int AW = $clog2(CAPACITY);
   localparam int LW = $clog2(CAPACITY + 1);
   localparam int CW = (LW > START_W) ? LW : START_W;

   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_CHECK = 3'd2;
   localparam logic [2:0] S_MVRD  = 3'd3;
   localparam logic [2:0] S_MVWR  = 3'd4;
   localparam logic [2:0] S_FILL  = 3'd5;
   localparam logic [2:0] S_EDIT  = 3'd6;

   logic [CHAR_W-1:0] store [CAPACITY];
   logic [CHAR_W-1:0] rdata_ff;

   logic [2:0]        state_ff, state_in;
   logic [AW-1:0]     clr_ff, clr_in;
   logic [LW-1:0]     lo_ff, lo_in;
   logic [AW-1:0]     hi_ff, hi_in;
   logic [OP_W-1:0]   op_ff, op_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [CHAR_W-1:0] ch_ff, ch_in;
   logic [LW-1:0]     tgt_ff, tgt_in;
   logic              left_ff, left_in;
   logic [AW-1:0]     src_ff, src_in;
   logic [AW-1:0]     dst_ff, dst_in;
   logic              pend_ff, pend_in;

   logic              we;
   logic [AW-1:0]     waddr;
   logic [CHAR_W-1:0] wdata;
   logic              re;
   logic [AW-1:0]     raddr;

   logic [LW-1:0]     hi_p1, gsz, len;
   logic              empty;
   logic [CW-1:0]     pos_c, len_c;
   logic [LW-1:0]     tgt_now;
   logic [LW-1:0]     base_lo, ed_lo;
   logic [AW-1:0]     base_hi;
   logic [AW-1:0]     ed_addr;
   logic [CHAR_W-1:0] ed_data;
   logic [LW-1:0]     mv_lo;
   logic [AW-1:0]     mv_hi;

   // store: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (we) begin
         store[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= store[raddr];
      end
   end

   always_comb begin
      hi_p1   = LW'(hi_ff) + LW'(1);
      empty   = (lo_ff == hi_p1);
      gsz     = hi_p1 - lo_ff;
      len     = LW'(CAPACITY) - gsz;
      pos_c   = CW'(pos_ff);
      len_c   = CW'(len);
      tgt_now = (op_ff == OP_INSERT) ? LW'(pos_c) : LW'(pos_c + CW'(1));

      // delete into an empty gap relabels the gap at the edit point first
      if (state_ff == S_CHECK && op_ff == OP_DELETE && empty) begin
         base_lo = tgt_now;
         base_hi = AW'(pos_ff);
      end else begin
         base_lo = lo_ff;
         base_hi = hi_ff;
      end
      if (op_ff == OP_INSERT) begin
         ed_lo   = base_lo + LW'(1);
         ed_addr = AW'(base_lo);
         ed_data = ch_ff;
      end else begin
         ed_lo   = base_lo - LW'(1);
         ed_addr = AW'(ed_lo);
         ed_data = fill_char;
      end

      if (left_ff) begin
         mv_lo = lo_ff - LW'(1);
         mv_hi = hi_ff - AW'(1);
      end else begin
         mv_lo = lo_ff + LW'(1);
         mv_hi = hi_ff + AW'(1);
      end
   end

   always_comb begin
      state_in = state_ff;
      clr_in   = clr_ff;
      lo_in    = lo_ff;
      hi_in    = hi_ff;
      op_in    = op_ff;
      pos_in   = pos_ff;
      ch_in    = ch_ff;
      tgt_in   = tgt_ff;
      left_in  = left_ff;
      src_in   = src_ff;
      dst_in   = dst_ff;
      pend_in  = pend_ff;
      we       = 1'b0;
      waddr    = ed_addr;
      wdata    = ed_data;
      re       = 1'b0;
      raddr    = AW'(req_position);
      req_ready = 1'b0;
      done     = 1'b0;
      rsp.status    = STAT_DONE;
      rsp.read_char = '0;
      rsp.gap_start = START_W'(lo_ff);
      rsp.gap_end   = END_W'(hi_ff);

      case (state_ff)
         S_CLEAR: begin
            we    = 1'b1;
            waddr = clr_ff;
            wdata = RESET_FILL;
            clr_in = clr_ff + AW'(1);
            if (clr_ff == AW'(CAPACITY - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               re       = 1'b1;
               op_in    = req_op;
               pos_in   = req_position;
               ch_in    = req_char_in;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            case (op_ff)
               OP_INSERT, OP_DELETE: begin
                  if (op_ff == OP_INSERT && empty) begin
                     rsp.status = STAT_FULL;
                     done       = rsp_free;
                  end else if ((op_ff == OP_INSERT && pos_c > len_c) ||
                               (op_ff == OP_DELETE && pos_c >= len_c)) begin
                     rsp.status = STAT_RANGE;
                     done       = rsp_free;
                  end else if (empty || tgt_now == lo_ff) begin
                     // edit right at the gap, no characters move
                     we            = 1'b1;
                     rsp.gap_start = START_W'(ed_lo);
                     rsp.gap_end   = END_W'(base_hi);
                     done          = rsp_free;
                     if (rsp_free) begin
                        lo_in = ed_lo;
                        hi_in = base_hi;
                     end
                  end else begin
                     tgt_in   = tgt_now;
                     left_in  = (tgt_now < lo_ff);
                     pend_in  = 1'b0;
                     state_in = S_MVRD;
                  end
               end
               OP_READ: begin
                  if (pos_c >= CW'(CAPACITY)) begin
                     rsp.status = STAT_RANGE;
                  end else begin
                     rsp.read_char = rdata_ff;
                  end
                  done = rsp_free;
               end
               default: begin
                  done = rsp_free;
               end
            endcase
            if (done) begin
               state_in = S_IDLE;
            end
         end
         S_MVRD: begin
            // fetch the next char; retire the fill of the slot vacated last step
            re    = 1'b1;
            raddr = left_ff ? AW'(mv_lo) : mv_hi;
            we    = pend_ff;
            waddr = src_ff;
            wdata = fill_char;
            src_in   = raddr;
            dst_in   = left_ff ? hi_ff : AW'(lo_ff);
            lo_in    = mv_lo;
            hi_in    = mv_hi;
            state_in = S_MVWR;
         end
         S_MVWR: begin
            we      = 1'b1;
            waddr   = dst_ff;
            wdata   = rdata_ff;
            pend_in = 1'b1;
            state_in = (lo_ff == tgt_ff) ? S_FILL : S_MVRD;
         end
         S_FILL: begin
            we       = 1'b1;
            waddr    = src_ff;
            wdata    = fill_char;
            state_in = S_EDIT;
         end
         S_EDIT: begin
            we            = 1'b1;
            rsp.gap_start = START_W'(ed_lo);
            done          = rsp_free;
            if (rsp_free) begin
               lo_in    = ed_lo;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff   <= '0;
         lo_ff    <= '0;
         hi_ff    <= AW'(CAPACITY - 1);
         pend_ff  <= 1'b0;
         left_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         lo_ff    <= lo_in;
         hi_ff    <= hi_in;
         pend_ff  <= pend_in;
         left_ff  <= left_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff  <= op_in;
      pos_ff <= pos_in;
      ch_ff  <= ch_in;
      tgt_ff <= tgt_in;
      src_ff <= src_in;
      dst_ff <= dst_in;
   end

endmodule

FILE: rtl/gbe_checker.sv
`timescale 1ns / 1ps

module gbe_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [gbe_pkg::STAT_W-1:0]   rsp_status,
   input logic [gbe_pkg::CHAR_W-1:0]   rsp_read_char,
   input logic [gbe_pkg::START_W-1:0]  rsp_gap_start,
   input logic [gbe_pkg::END_W-1:0]    rsp_gap_end
);
   import gbe_pkg::*;

   // stalled word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
      $stable(rsp_read_char) && $stable(rsp_gap_start) && $stable(rsp_gap_end))
      else $error("rsp word changed while stalled");

   // gap never inverted past empty
   a_gap_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_gap_start <= ({1'b0, rsp_gap_end} + START_W'(1)))
      else $error("gap start beyond gap end plus one");

   a_rd_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STAT_DONE |-> rsp_read_char == '0)
      else $error("read_char nonzero on rejected item");

   // one item in flight
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while busy");

   // clearing pass follows reset
   a_clear: assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("request ready during clearing pass");

endmodule

bind gap_buffer_editor gbe_checker u_gbe_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_ready     (req_ready),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_status    (rsp_status),
   .rsp_read_char (rsp_read_char),
   .rsp_gap_start (rsp_gap_start),
   .rsp_gap_end   (rsp_gap_end)
);
